>>> rtl/core/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and widths for the Diophantine solution range block.
// ----------------------------------------------------------------------------
package dsr_pkg;

    localparam int NUM_W = 66;
    localparam int DEN_W = 34;
    localparam int OUT_W = 296;

    localparam logic [1:0] STAT_NONE   = 2'd0;
    localparam logic [1:0] STAT_SOLVED = 2'd1;
    localparam logic [1:0] STAT_DEGEN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT,
        ST_EMS,
        ST_EMT,
        ST_EUPD,
        ST_SIGN,
        ST_MX,
        ST_MY,
        ST_MDONE,
        ST_DONE
    } dsr_state_t;

    typedef enum logic [2:0] {
        SEL_EUC,
        SEL_C,
        SEL_B,
        SEL_A,
        SEL_K
    } dsr_sel_t;

endpackage

>>> rtl/core/dsr_divider.sv
// ----------------------------------------------------------------------------
// dsr_divider
// Radix-2 restoring signed divider, truncating quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module dsr_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              short_mode,
    input  logic signed [dsr_pkg::NUM_W-1:0]  num,
    input  logic signed [dsr_pkg::DEN_W-1:0]  den,
    output logic                              busy,
    output logic                              done,
    output logic signed [dsr_pkg::NUM_W-1:0]  quo,
    output logic signed [dsr_pkg::DEN_W-1:0]  rem
);
    import dsr_pkg::*;

    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-2:0] den_reg, den_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W:0]   trial;

    assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
    assign trial   = {1'b0, rem_reg[DEN_W-2:0], acc_reg[NUM_W-1]} - {2'b00, den_reg};

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start)
        begin
            acc_next  = short_mode ? (num_mag << (DEN_W - 1)) : num_mag;
            rem_next  = '0;
            den_next  = den_mag[DEN_W-2:0];
            cnt_next  = short_mode ? 7'(DEN_W - 1) : 7'(NUM_W);
            busy_next = 1'b1;
            qneg_next = num[NUM_W-1] ^ den[DEN_W-1];
            rneg_next = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
                rem_next = trial[DEN_W-1:0];
            else
                rem_next = {rem_reg[DEN_W-2:0], acc_reg[NUM_W-1]};
            acc_next = {acc_reg[NUM_W-2:0], ~trial[DEN_W]};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = qneg_reg ? (~acc_reg + 1'b1) : acc_reg;
    assign rem  = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

>>> rtl/core/diophantine_solution_range.sv
// ----------------------------------------------------------------------------
// diophantine_solution_range
// Solves a*x + b*y = c and bounds the solution parameter k to an x/y box.
// ----------------------------------------------------------------------------
// One request enters on the s_ stream (coef_a, coef_b, rhs_c, x_low, x_high,
// y_low, y_high packed in s_tdata). One result leaves on the m_ stream:
// status in m_tuser, the solution fields in m_tdata.
// An extended Euclid pass runs on a shared restoring divider and a shared
// 34x34 multiplier; each Euclid step is a 33-bit division plus two
// multiplies. Then come the 33-bit divisions c/g, b/g and a/g and the four
// 66-bit k bound divisions. A request with no solution (g does not divide
// c) stops after c/g, and a degenerate request (a or b zero) goes straight
// to the result.
// One request is worked on at a time; s_tready is high only while idle.
// The finished result sits in an output register; a new request is taken
// while it waits, and the next result waits in the final step until the
// receiver raises m_tready. Reset clears the sequencer and drops any
// pending result.
module diophantine_solution_range #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // coef_a, coef_b, rhs_c, x_low, x_high, y_low, y_high (lowest first)
    input  logic [((7*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // base_x, base_y, divisor_g, step_x, step_y, k_lowest, k_highest
    output logic [dsr_pkg::OUT_W-1:0]    m_tdata,
    // status
    output logic [1:0]                   m_tuser
);
    import dsr_pkg::*;

    localparam int W = COEF_WIDTH;

    dsr_state_t state_reg, state_next;
    dsr_sel_t   sel_reg, sel_next;

    logic signed [DEN_W-1:0] a_reg, b_reg, c_reg, lx_reg, rx_reg, ly_reg, ry_reg;
    logic signed [DEN_W-1:0] r0_reg, r1_reg, s0_reg, s1_reg, t0_reg, t1_reg, q_reg;
    logic signed [DEN_W-1:0] cg_reg, sx_reg, sy_reg;
    logic signed [63:0]      x0_reg, y0_reg;
    logic signed [NUM_W-1:0] kmin_reg, kmax_reg;
    logic signed [67:0]      prod_reg;
    logic [1:0]              kidx_reg, stat_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic [1:0]              m_tuser_reg;
    logic [OUT_W-1:0]        out_data;

    logic signed [DEN_W-1:0] in_f [7];
    logic signed [DEN_W-1:0] mul_a, mul_b;
    logic signed [NUM_W-1:0] div_num, q_adj, x0_w, y0_w;
    logic signed [DEN_W-1:0] div_den, div_rem;
    logic signed [NUM_W-1:0] div_quo;
    logic                    div_start, div_busy, div_done, out_free, rnz, adj;

    for (genvar i = 0; i < 7; i++)
    begin : g_in
        assign in_f[i] = DEN_W'(signed'(s_tdata[i*W +: W]));
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign x0_w     = NUM_W'(x0_reg);
    assign y0_w     = NUM_W'(y0_reg);

    always_comb
    begin
        div_num = '0;
        div_den = r0_reg;
        case (sel_reg)
            SEL_EUC:
            begin
                div_num = NUM_W'(r0_reg);
                div_den = r1_reg;
            end
            SEL_C: div_num = NUM_W'(c_reg);
            SEL_B: div_num = NUM_W'(b_reg);
            SEL_A: div_num = NUM_W'(a_reg);
            SEL_K:
            begin
                case (kidx_reg)
                    2'd0: div_num = NUM_W'(b_reg > 0 ? lx_reg : rx_reg) - x0_w;
                    2'd1: div_num = NUM_W'(b_reg > 0 ? rx_reg : lx_reg) - x0_w;
                    2'd2: div_num = y0_w - NUM_W'(a_reg > 0 ? ry_reg : ly_reg);
                    default: div_num = y0_w - NUM_W'(a_reg > 0 ? ly_reg : ry_reg);
                endcase
                div_den = kidx_reg[1] ? sy_reg : sx_reg;
            end
            default: div_num = '0;
        endcase
    end

    assign div_start = (state_reg == ST_DIV);

    dsr_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .short_mode (sel_reg != SEL_K),
        .num        (div_num),
        .den        (div_den),
        .busy       (div_busy),
        .done       (div_done),
        .quo        (div_quo),
        .rem        (div_rem)
    );

    assign rnz = (div_rem != '0);
    assign adj = kidx_reg[0] ? (rnz && (div_rem[DEN_W-1] != div_den[DEN_W-1]))
                             : (rnz && (div_rem[DEN_W-1] == div_den[DEN_W-1]));
    assign q_adj = !adj ? div_quo : (kidx_reg[0] ? div_quo - 1'b1 : div_quo + 1'b1);

    always_comb
    begin
        case (state_reg)
            ST_EMS:  begin mul_a = q_reg;  mul_b = s1_reg; end
            ST_EMT:  begin mul_a = q_reg;  mul_b = t1_reg; end
            ST_MX:   begin mul_a = s0_reg; mul_b = cg_reg; end
            default: begin mul_a = t0_reg; mul_b = cg_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(mul_a) * 68'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = (in_f[0] == '0 || in_f[1] == '0) ? ST_DONE : ST_DIV;
            ST_DIV:  state_next = ST_WAIT;
            ST_WAIT:
                if (div_done)
                begin
                    case (sel_reg)
                        SEL_EUC: state_next = ST_EMS;
                        SEL_C:   state_next = rnz ? ST_DONE : ST_DIV;
                        SEL_B:   state_next = ST_DIV;
                        SEL_A:   state_next = ST_MX;
                        default: state_next = (kidx_reg == 2'd3) ? ST_DONE : ST_DIV;
                    endcase
                end
            ST_EMS:  state_next = ST_EMT;
            ST_EMT:  state_next = ST_EUPD;
            ST_EUPD: state_next = (r1_reg == '0) ? ST_SIGN : ST_DIV;
            ST_SIGN: state_next = ST_DIV;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MDONE;
            ST_MDONE: state_next = ST_DIV;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sel_next = sel_reg;
        case (state_reg)
            ST_IDLE:  sel_next = SEL_EUC;
            ST_SIGN:  sel_next = SEL_C;
            ST_MDONE: sel_next = SEL_K;
            ST_WAIT:
                if (div_done)
                begin
                    case (sel_reg)
                        SEL_C:   sel_next = SEL_B;
                        SEL_B:   sel_next = SEL_A;
                        default: sel_next = sel_reg;
                    endcase
                end
            default: sel_next = sel_reg;
        endcase
    end

    always_comb
    begin
        out_data = '0;
        if (stat_reg != STAT_DEGEN)
            out_data[159:128] = r0_reg[31:0];
        if (stat_reg == STAT_SOLVED)
        begin
            out_data[63:0]    = x0_reg;
            out_data[127:64]  = y0_reg;
            out_data[191:160] = sx_reg[31:0];
            out_data[223:192] = sy_reg[31:0];
            out_data[258:224] = kmin_reg[34:0];
            out_data[293:259] = kmax_reg[34:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sel_reg      <= SEL_EUC;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                a_reg  <= in_f[0];
                b_reg  <= in_f[1];
                c_reg  <= in_f[2];
                lx_reg <= in_f[3];
                rx_reg <= in_f[4];
                ly_reg <= in_f[5];
                ry_reg <= in_f[6];
                r0_reg <= in_f[0];
                r1_reg <= in_f[1];
                s0_reg <= DEN_W'(1);
                s1_reg <= '0;
                t0_reg <= '0;
                t1_reg <= DEN_W'(1);
                kidx_reg <= '0;
                stat_reg <= (in_f[0] == '0 || in_f[1] == '0) ? STAT_DEGEN : STAT_SOLVED;
            end
            ST_WAIT:
                if (div_done)
                begin
                    case (sel_reg)
                        SEL_EUC:
                        begin
                            q_reg  <= div_quo[DEN_W-1:0];
                            r0_reg <= r1_reg;
                            r1_reg <= div_rem;
                        end
                        SEL_C:
                        begin
                            cg_reg <= div_quo[DEN_W-1:0];
                            if (rnz)
                                stat_reg <= STAT_NONE;
                        end
                        SEL_B: sx_reg <= div_quo[DEN_W-1:0];
                        SEL_A: sy_reg <= div_quo[DEN_W-1:0];
                        default:
                        begin
                            case (kidx_reg)
                                2'd0: kmin_reg <= q_adj;
                                2'd1: kmax_reg <= q_adj;
                                2'd2: if (q_adj > kmin_reg) kmin_reg <= q_adj;
                                default: if (q_adj < kmax_reg) kmax_reg <= q_adj;
                            endcase
                            kidx_reg <= kidx_reg + 2'd1;
                        end
                    endcase
                end
            ST_EMT:
            begin
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - prod_reg[DEN_W-1:0];
            end
            ST_EUPD:
            begin
                t0_reg <= t1_reg;
                t1_reg <= t0_reg - prod_reg[DEN_W-1:0];
            end
            ST_SIGN:
                if (r0_reg < 0)
                begin
                    r0_reg <= -r0_reg;
                    s0_reg <= -s0_reg;
                    t0_reg <= -t0_reg;
                end
            ST_MY:    x0_reg <= prod_reg[63:0];
            ST_MDONE: y0_reg <= prod_reg[63:0];
            default: ;
        endcase

        if (state_reg == ST_DONE && out_free)
        begin
            m_tuser_reg <= stat_reg;
            m_tdata_reg <= out_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_busy)
        else $error("divider busy while idle");
    a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");
    a_wait_sel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |=> div_busy)
        else $error("divider did not start");

endmodule

>>> test/diophantine_solution_range_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diophantine_solution_range_chk
// Watches both streams, computes the expected solution range for every
// accepted request and compares each result with the oldest expectation.
// ----------------------------------------------------------------------------
module diophantine_solution_range_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [223:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [295:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           accepted
);

    typedef struct packed {
        logic [1:0]         status;
        logic signed [34:0] k_highest;
        logic signed [34:0] k_lowest;
        logic signed [31:0] step_y;
        logic signed [31:0] step_x;
        logic [31:0]        divisor_g;
        logic signed [63:0] base_y;
        logic signed [63:0] base_x;
    } solution_t;

    solution_t solutions_due[$];
    int        stat_seen[3];

    function automatic longint div_floor(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0)))
            q--;
        return q;
    endfunction

    function automatic longint div_ceil(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) == (d < 0)))
            q++;
        return q;
    endfunction

    function automatic solution_t solve_range(logic [223:0] d);
        solution_t s;
        longint a, b, c, lx, rx, ly, ry;
        longint r0, r1, s0, s1, t0, t1, q, tmp, g, x0, y0, sx, sy, kmin, kmax, t;
        a  = longint'(signed'(d[31:0]));
        b  = longint'(signed'(d[63:32]));
        c  = longint'(signed'(d[95:64]));
        lx = longint'(signed'(d[127:96]));
        rx = longint'(signed'(d[159:128]));
        ly = longint'(signed'(d[191:160]));
        ry = longint'(signed'(d[223:192]));
        s = '0;
        if (a == 0 || b == 0)
        begin
            s.status = dsr_pkg::STAT_DEGEN;
            return s;
        end
        r0 = a; r1 = b; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            tmp = r0 - q * r1; r0 = r1; r1 = tmp;
            tmp = s0 - q * s1; s0 = s1; s1 = tmp;
            tmp = t0 - q * t1; t0 = t1; t1 = tmp;
        end
        if (r0 < 0)
        begin
            r0 = -r0; s0 = -s0; t0 = -t0;
        end
        g = r0;
        s.divisor_g = g[31:0];
        if (c % g != 0)
        begin
            s.status = dsr_pkg::STAT_NONE;
            return s;
        end
        x0 = s0 * (c / g);
        y0 = t0 * (c / g);
        sx = b / g;
        sy = a / g;
        if (b > 0)
        begin
            kmin = div_ceil(lx - x0, sx);
            kmax = div_floor(rx - x0, sx);
        end
        else
        begin
            kmin = div_ceil(rx - x0, sx);
            kmax = div_floor(lx - x0, sx);
        end
        if (a > 0)
        begin
            t = div_ceil(y0 - ry, sy);
            if (t > kmin) kmin = t;
            t = div_floor(y0 - ly, sy);
            if (t < kmax) kmax = t;
        end
        else
        begin
            t = div_ceil(y0 - ly, sy);
            if (t > kmin) kmin = t;
            t = div_floor(y0 - ry, sy);
            if (t < kmax) kmax = t;
        end
        s.status    = dsr_pkg::STAT_SOLVED;
        s.base_x    = x0;
        s.base_y    = y0;
        s.step_x    = sx[31:0];
        s.step_y    = sy[31:0];
        s.k_lowest  = kmin[34:0];
        s.k_highest = kmax[34:0];
        return s;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        solution_t w;
        solution_t g;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                solutions_due.insert(solutions_due.size(), solve_range(s_tdata));
                accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (solutions_due.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    w = solutions_due.pop_front();
                    g = {m_tuser, m_tdata[293:0]};
                    stat_seen[w.status]++;
                    if (g.status != w.status)       report("status", g.status, w.status);
                    if (g.base_x != w.base_x)       report("base_x", g.base_x, w.base_x);
                    if (g.base_y != w.base_y)       report("base_y", g.base_y, w.base_y);
                    if (g.divisor_g != w.divisor_g) report("divisor_g", g.divisor_g, w.divisor_g);
                    if (g.step_x != w.step_x)       report("step_x", g.step_x, w.step_x);
                    if (g.step_y != w.step_y)       report("step_y", g.step_y, w.step_y);
                    if (g.k_lowest != w.k_lowest)   report("k_lowest", g.k_lowest, w.k_lowest);
                    if (g.k_highest != w.k_highest) report("k_highest", g.k_highest, w.k_highest);
                end
            end
        end
        pending = solutions_due.size();
    end

endmodule

>>> test/diophantine_solution_range_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diophantine_solution_range_tb
// Drives directed and random equations with boxes into the solver under
// random stalls on both streams; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module diophantine_solution_range_tb;

    localparam int N_RANDOM = 1230;
    localparam int WATCHDOG = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [295:0] m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    int           accepted;
    bit           hold_result;
    int           idle_cycles;

    diophantine_solution_range i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    diophantine_solution_range_chk i_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .accepted (accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 300);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(0, 3);
            4: return $urandom >> $urandom_range(0, 31);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic [223:0] rand_request();
        logic [31:0] a, b, c, lx, hx, ly, hy, m;
        a = rand_value();
        b = rand_value();
        c = rand_value();
        if ($urandom_range(0, 2) != 0)
        begin
            m = 32'($signed($urandom_range(0, 2000)) - 1000);
            c = $signed(a) * $signed(m) + $signed(b) * $signed(rand_value() >>> 16);
        end
        lx = rand_value();
        ly = rand_value();
        if ($urandom_range(0, 3) != 0)
        begin
            hx = lx + ($urandom >> $urandom_range(0, 31));
            hy = ly + ($urandom >> $urandom_range(0, 31));
        end
        else
        begin
            hx = rand_value();
            hy = rand_value();
        end
        return {hy, ly, hx, lx, c, b, a};
    endfunction

    task automatic send(logic [223:0] d);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_eq(int a, int b, int c, int lx, int hx, int ly, int hy);
        send({hy, ly, hx, lx, c, b, a});
    endtask

    initial
    begin
        m_tready = 1'b0;
        hold_result = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int n;
            if (hold_result)
            begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_result = 1'b0;
            end
            n = gap_len();
            m_tready <= (n == 0);
            repeat (n > 0 ? n : 1) @(posedge clk);
            if (n > 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("diophantine_solution_range_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_eq(0, 5, 10, -10, 10, -10, 10);
        send_eq(7, 0, 14, -10, 10, -10, 10);
        send_eq(0, 0, 0, 0, 0, 0, 0);
        send_eq(4, 6, 7, -100, 100, -100, 100);
        send_eq(4, 6, 8, -100, 100, -100, 100);
        send_eq(-4, 6, 8, -100, 100, -100, 100);
        send_eq(4, -6, -8, -100, 100, -100, 100);
        send_eq(-4, -6, 8, -100, 100, -100, 100);
        send_eq(3, 5, 1, 10, -10, -10, 10);
        send_eq(3, 5, 1, 5, 5, 5, 5);
        send_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_eq(32'h8000_0000, 1, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_eq(32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_eq(1134903170, 1836311903, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_eq(-1836311903, 1134903170, 32'h8000_0001,
                -1000, 1000, -1000, 1000);
        send_eq(1, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_eq(-1, -1, -1, -3, 3, -3, 3);
        send({224{1'b1}});
        send_eq(12, 18, 30, -50, -50, 0, 100);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        hold_result = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            send(rand_request());
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d requests: %0d no solution, %0d solved, %0d degenerate",
                 accepted, i_chk.stat_seen[0], i_chk.stat_seen[1], i_chk.stat_seen[2]);
        $display("stalls on both streams, including a long result hold-off");
        if (errors == 0)
            $display("diophantine_solution_range_tb: done, clean");
        else
            $display("diophantine_solution_range_tb: done, errors");
        $finish;
    end

endmodule
